// ===== src/spx_pkg.sv =====
// Shared types, constants and arithmetic helpers for the six-tap interpolator.
`timescale 1ns / 1ps
package spx_pkg;

    localparam int DefMaxBlockWidth = 16;
    localparam int Lines            = 5;
    localparam int Taps             = 6;
    localparam int PixW             = 8;
    localparam int TapW             = 9;
    localparam int ProdW            = 18;
    localparam int SumW             = 20;

    // block size codes
    localparam logic [1:0] SIZE_4X4   = 2'd0;
    localparam logic [1:0] SIZE_8X4   = 2'd1;
    localparam logic [1:0] SIZE_8X8   = 2'd2;
    localparam logic [1:0] SIZE_16X16 = 2'd3;

    typedef logic signed [TapW-1:0] t_tap;
    typedef t_tap [Taps-1:0] t_taps;
    typedef logic [Taps-1:0][PixW-1:0] t_pix6;
    typedef logic [Lines-1:0][PixW-1:0] t_line_word;

    // per-item sideband carried down the pipeline
    typedef struct packed {
        logic            out_en;
        logic [3:0]      row;
        logic [3:0]      col;
        logic            last;
        logic            avg;
        logic [PixW-1:0] prior;
        logic [2:0]      hphase;
        logic [2:0]      vphase;
        logic [2:0]      slot;
    } t_side;

    // six-tap coefficient set for an eighth-pel phase
    function automatic t_taps tap_set(input logic [2:0] phase);
        t_taps t;
        unique case (phase)
            3'd0: t = '{9'sd0,  9'sd0,   9'sd0,   9'sd128, 9'sd0,   9'sd0};
            3'd1: t = '{9'sd0,  -9'sd1,  9'sd12,  9'sd123, -9'sd6,  9'sd0};
            3'd2: t = '{9'sd1,  -9'sd8,  9'sd36,  9'sd108, -9'sd11, 9'sd2};
            3'd3: t = '{9'sd0,  -9'sd6,  9'sd50,  9'sd93,  -9'sd9,  9'sd0};
            3'd4: t = '{9'sd3,  -9'sd16, 9'sd77,  9'sd77,  -9'sd16, 9'sd3};
            3'd5: t = '{9'sd0,  -9'sd9,  9'sd93,  9'sd50,  -9'sd6,  9'sd0};
            3'd6: t = '{9'sd2,  -9'sd11, 9'sd108, 9'sd36,  -9'sd8,  9'sd1};
            3'd7: t = '{9'sd0,  -9'sd6,  9'sd123, 9'sd12,  -9'sd1,  9'sd0};
            default: t = '0;
        endcase
        return t;
    endfunction

    // add 64, shift right by 7, clamp to 0..255
    function automatic logic [PixW-1:0] round_clamp(input logic signed [SumW-1:0] s);
        logic signed [SumW-1:0] t;
        logic [PixW-1:0]        r;
        t = s + $signed(SumW'(64));
        if (t[SumW-1]) begin
            r = '0;
        end else if (|t[SumW-2:PixW+7]) begin
            r = '1;
        end else begin
            r = t[PixW+6:7];
        end
        return r;
    endfunction

    // block width before saturation
    function automatic logic [4:0] size_width(input logic [1:0] size);
        logic [4:0] w;
        unique case (size)
            SIZE_4X4:   w = 5'd4;
            SIZE_8X4:   w = 5'd8;
            SIZE_8X8:   w = 5'd8;
            SIZE_16X16: w = 5'd16;
            default:    w = 5'd4;
        endcase
        return w;
    endfunction

    function automatic logic [4:0] size_height(input logic [1:0] size);
        logic [4:0] h;
        unique case (size)
            SIZE_4X4:   h = 5'd4;
            SIZE_8X4:   h = 5'd4;
            SIZE_8X8:   h = 5'd8;
            SIZE_16X16: h = 5'd16;
            default:    h = 5'd4;
        endcase
        return h;
    endfunction

endpackage

// ===== src/spx_filter6.sv =====
// Two-stage six-tap filter: registered products, then sum with round and clamp.
`timescale 1ns / 1ps
module spx_filter6 (
    input  logic                      i_clk,
    input  logic                      i_prod_en,
    input  logic                      i_sum_en,
    input  spx_pkg::t_taps            i_taps,
    input  spx_pkg::t_pix6            i_pix,
    output logic [spx_pkg::PixW-1:0]  o_pix
);
    import spx_pkg::*;

    logic signed [ProdW-1:0] r_prod [Taps];
    logic signed [SumW-1:0]  sum;
    logic [PixW-1:0]         r_pix;

    // stage 1: one product per tap
    always_ff @(posedge i_clk) begin
        if (i_prod_en) begin
            for (int k = 0; k < Taps; k++) begin
                r_prod[k] <= ProdW'($signed(i_taps[k]) * $signed({1'b0, i_pix[k]}));
            end
        end
    end

    // stage 2: accumulate, round, clamp
    always_comb begin
        sum = '0;
        for (int k = 0; k < Taps; k++) begin
            sum = sum + SumW'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sum_en) begin
            r_pix <= round_clamp(sum);
        end
    end

    assign o_pix = r_pix;

endmodule

// ===== src/spx_line_mem.sv =====
// Line store: one word per column holding the five buffered horizontal results.
`timescale 1ns / 1ps
module spx_line_mem #(
    parameter int MAX_BLOCK_WIDTH = spx_pkg::DefMaxBlockWidth,
    parameter int AddrW           = $clog2(MAX_BLOCK_WIDTH)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AddrW-1:0]    i_rd_addr,
    output spx_pkg::t_line_word o_rd_data,
    input  logic                i_wr_en,
    input  logic [AddrW-1:0]    i_wr_addr,
    input  spx_pkg::t_line_word i_wr_data
);
    import spx_pkg::*;

    t_line_word r_mem [MAX_BLOCK_WIDTH];
    t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, held while the reading stage stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/subpel_sixtap_interpolator_unit.sv =====
// Top level of the six-tap sub-pixel interpolator: window tracking and pipeline control.
//
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_ready     | source, prior, start, phases, size, avg
//  out     | output    | o_out_valid / i_out_ready   | pixel, row, col, last
//
// One source pixel is taken per clock while the output side is ready; a result passes
// registered stages S1 to S5 before it is presented. The line store column word is read
// as the item enters the product stage and written back while it sits in S3 on a
// separate write port, so one pixel per clock is sustained while the output side is ready.
// Reset (synchronous, active low) clears position, settings, pixel taps and valids.
// A stalled output fills pipeline bubbles before o_in_ready drops.
`timescale 1ns / 1ps
module subpel_sixtap_interpolator_unit #(
    parameter int MAX_BLOCK_WIDTH = spx_pkg::DefMaxBlockWidth
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [spx_pkg::PixW-1:0] i_source_pixel,
    input  logic [spx_pkg::PixW-1:0] i_prior_pixel,
    input  logic                     i_start_of_block,
    input  logic [2:0]               i_horiz_phase,
    input  logic [2:0]               i_vert_phase,
    input  logic [1:0]               i_block_size,
    input  logic                     i_average_mode,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [spx_pkg::PixW-1:0] o_out_pixel,
    output logic [3:0]               o_out_row,
    output logic [3:0]               o_out_col,
    output logic                     o_last_of_block
);
    import spx_pkg::*;

    localparam int         AddrW = $clog2(MAX_BLOCK_WIDTH);
    localparam logic [4:0] MaxW  = 5'(MAX_BLOCK_WIDTH);

    // window state
    logic [Lines-1:0][PixW-1:0] r_row_win;
    logic [4:0]                 r_row, r_col;
    logic [2:0]                 r_slot;
    logic [8:0]                 r_settings;

    // pipeline stages
    logic       r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    t_side      r_s1_side, r_s2_side, r_s3_side, r_s4_side, r_s5_side;
    t_pix6      r_s1_pix;
    t_line_word r_s3_word;

    logic adv1, adv2, adv3, adv4, accept;

    // current item decode
    logic [8:0] set_eff;
    logic [4:0] w_raw, w_eff, h_eff, cur_r, cur_c, n_row, n_col;
    logic [2:0] cur_slot, n_slot;
    logic       work;
    t_side      side0;
    t_pix6      pix0;

    // memory and filter connections
    t_line_word rd_word, wr_word;
    t_pix6      vpix;
    logic [PixW-1:0] hv, vres;
    logic [PixW:0]   avg_sum;

    // stage handshakes, bubbles collapse toward the output
    always_comb begin
        adv4       = r_s4_valid && (!r_s5_valid || i_out_ready);
        adv3       = r_s3_valid && (!r_s3_side.out_en || !r_s4_valid || adv4);
        adv2       = r_s2_valid && (!r_s3_valid || adv3);
        adv1       = r_s1_valid && (!r_s2_valid || adv2);
        o_in_ready = !r_s1_valid || adv1;
        accept     = i_in_valid && o_in_ready;
    end

    // settings, position and next position
    always_comb begin
        set_eff  = i_start_of_block
                 ? {i_average_mode, i_block_size, i_vert_phase, i_horiz_phase}
                 : r_settings;
        w_raw    = size_width(set_eff[7:6]);
        w_eff    = (w_raw > MaxW) ? MaxW : w_raw;
        h_eff    = size_height(set_eff[7:6]);
        cur_r    = i_start_of_block ? 5'd0 : r_row;
        cur_c    = i_start_of_block ? 5'd0 : r_col;
        cur_slot = i_start_of_block ? 3'd0 : r_slot;
        work     = (cur_c >= 5'd5) && (cur_c < w_eff + 5'd5) && (cur_r < h_eff + 5'd5);

        n_col  = cur_c + 5'd1;
        n_row  = cur_r;
        n_slot = cur_slot;
        if (n_col >= w_eff + 5'd5) begin
            n_col  = '0;
            n_row  = cur_r + 5'd1;
            n_slot = (cur_slot == 3'd4) ? 3'd0 : cur_slot + 3'd1;
            if (n_row >= h_eff + 5'd5) begin
                n_row  = '0;
                n_slot = '0;
            end
        end

        side0.out_en = (cur_r >= 5'd5);
        side0.row    = 4'(cur_r - 5'd5);
        side0.col    = 4'(cur_c - 5'd5);
        side0.last   = (cur_r == h_eff + 5'd4) && (cur_c == w_eff + 5'd4);
        side0.avg    = set_eff[8];
        side0.prior  = i_prior_pixel;
        side0.hphase = set_eff[2:0];
        side0.vphase = set_eff[5:3];
        side0.slot   = cur_slot;

        for (int k = 0; k < Lines; k++) begin
            pix0[k] = r_row_win[k];
        end
        pix0[Taps-1] = i_source_pixel;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_win  <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_slot     <= '0;
            r_settings <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_row_win  <= {i_source_pixel, r_row_win[Lines-1:1]};
                r_row      <= n_row;
                r_col      <= n_col;
                r_slot     <= n_slot;
                r_settings <= set_eff;
            end
            if (accept)          r_s1_valid <= work;
            else if (adv1)       r_s1_valid <= 1'b0;
            if (adv1)            r_s2_valid <= 1'b1;
            else if (adv2)       r_s2_valid <= 1'b0;
            if (adv2)            r_s3_valid <= 1'b1;
            else if (adv3)       r_s3_valid <= 1'b0;
            if (adv3 && r_s3_side.out_en) r_s4_valid <= 1'b1;
            else if (adv4)       r_s4_valid <= 1'b0;
            if (adv4)            r_s5_valid <= 1'b1;
            else if (i_out_ready) r_s5_valid <= 1'b0;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_side <= side0;
            r_s1_pix  <= pix0;
        end
        if (adv1) r_s2_side <= r_s1_side;
        if (adv2) begin
            r_s3_side <= r_s2_side;
            r_s3_word <= rd_word;
        end
        if (adv3 && r_s3_side.out_en) r_s4_side <= r_s3_side;
        if (adv4) r_s5_side <= r_s4_side;
    end

    // horizontal pass: products in S2, result in S3
    spx_filter6 u_hfilt (
        .i_clk     (i_clk),
        .i_prod_en (adv1),
        .i_sum_en  (adv2),
        .i_taps    (tap_set(r_s1_side.hphase)),
        .i_pix     (r_s1_pix),
        .o_pix     (hv)
    );

    // column word: read as the item enters S2, written back while it sits in S3;
    // the same column recurs only a full window row later, so no overlap
    always_comb begin
        logic [3:0] idx;
        wr_word = r_s3_word;
        wr_word[r_s3_side.slot] = hv;
        for (int k = 0; k < Lines; k++) begin
            idx = 4'(r_s3_side.slot) + 4'(k);
            if (idx >= 4'(Lines)) idx = idx - 4'(Lines);
            vpix[k] = r_s3_word[idx[2:0]];
        end
        vpix[Taps-1] = hv;
    end

    spx_line_mem #(
        .MAX_BLOCK_WIDTH (MAX_BLOCK_WIDTH),
        .AddrW           (AddrW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (adv1),
        .i_rd_addr (r_s1_side.col[AddrW-1:0]),
        .o_rd_data (rd_word),
        .i_wr_en   (r_s3_valid),
        .i_wr_addr (r_s3_side.col[AddrW-1:0]),
        .i_wr_data (wr_word)
    );

    // vertical pass: products in S4, result in S5
    spx_filter6 u_vfilt (
        .i_clk     (i_clk),
        .i_prod_en (adv3 && r_s3_side.out_en),
        .i_sum_en  (adv4),
        .i_taps    (tap_set(r_s3_side.vphase)),
        .i_pix     (vpix),
        .o_pix     (vres)
    );

    // optional averaging with the prior pixel, rounding up
    assign avg_sum = {1'b0, vres} + {1'b0, r_s5_side.prior} + 9'd1;

    assign o_out_valid     = r_s5_valid;
    assign o_out_pixel     = r_s5_side.avg ? avg_sum[PixW:1] : vres;
    assign o_out_row       = r_s5_side.row;
    assign o_out_col       = r_s5_side.col;
    assign o_last_of_block = r_s5_side.last;

endmodule

// ===== dv/tb_subpel_sixtap_interpolator_unit.sv =====
// Self-checking testbench for the six-tap sub-pixel interpolator: directed windows, then random.
`timescale 1ns / 1ps
module tb_subpel_sixtap_interpolator_unit;
    import spx_pkg::*;

    localparam int MaxWidth   = DefMaxBlockWidth;
    localparam int IdlePct    = 34;
    localparam int NumItems   = 1750;
    localparam int DrainWait  = 20;
    localparam int CycleLimit = 400000;
    localparam int NumDir     = 11;

    // pixel patterns for a window
    typedef enum int {
        PAT_FLAT,
        PAT_CHECKER,
        PAT_RAMP,
        PAT_NOISE,
        PAT_RAIL
    } t_pat;

    // one input item
    typedef struct packed {
        logic [7:0] src;
        logic [7:0] prior;
        logic       start;
        logic [2:0] hph;
        logic [2:0] vph;
        logic [1:0] size;
        logic       avg;
    } t_pel_in;

    // one output pixel
    typedef struct packed {
        logic [7:0] pix;
        logic [3:0] row;
        logic [3:0] col;
        logic       last;
    } t_pel_out;

    // directed window: settings, content, length (0 = whole window), known pixel (-1 = none)
    typedef struct packed {
        logic       start;
        logic [1:0] size;
        logic [2:0] hph;
        logic [2:0] vph;
        logic       avg;
        t_pat       pat;
        int         level;
        int         prior;
        int         npix;
        int         want_pix;
    } t_win_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_rdy;
    logic [7:0] src_pix = '0;
    logic [7:0] prior_pix = '0;
    logic       sob = 1'b0;
    logic [2:0] hph = '0;
    logic [2:0] vph = '0;
    logic [1:0] bsize = SIZE_4X4;
    logic       avg_mode = 1'b0;
    logic       out_valid;
    logic       out_rdy = 1'b0;
    logic [7:0] out_pix;
    logic [3:0] out_row;
    logic [3:0] out_col;
    logic       out_last;

    logic       steady = 1'b0;
    int         errors = 0;
    int         cycles = 0;
    int         items_sent = 0;

    // predictor state
    int         row_taps [5] = '{default: 0};
    int         line_mem [5 * MaxWidth] = '{default: 0};
    int         pos_row = 0;
    int         pos_col = 0;
    logic [2:0] cur_h = '0;
    logic [2:0] cur_v = '0;
    logic [1:0] cur_size = SIZE_4X4;
    logic       cur_avg = 1'b0;
    t_pel_out   pending_pels [$];

    t_win_row dir_rows [NumDir] = '{
        '{1'b0, SIZE_4X4,   3'd0, 3'd0, 1'b0, PAT_FLAT,    100, 0,   0,   100},
        '{1'b1, SIZE_4X4,   3'd7, 3'd7, 1'b0, PAT_FLAT,    255, 0,   0,   255},
        '{1'b1, SIZE_8X4,   3'd4, 3'd4, 1'b1, PAT_FLAT,    255, 0,   0,   128},
        '{1'b1, SIZE_4X4,   3'd3, 3'd5, 1'b1, PAT_FLAT,    0,   255, 0,   128},
        '{1'b1, SIZE_4X4,   3'd4, 3'd4, 1'b0, PAT_CHECKER, 0,   -1,  0,   -1},
        '{1'b1, SIZE_8X8,   3'd2, 3'd6, 1'b0, PAT_RAMP,    0,   -1,  100, -1},
        '{1'b1, SIZE_4X4,   3'd6, 3'd3, 1'b1, PAT_NOISE,   0,   85,  0,   -1},
        '{1'b0, SIZE_4X4,   3'd0, 3'd0, 1'b0, PAT_FLAT,    200, 85,  0,   143},
        '{1'b1, SIZE_8X4,   3'd0, 3'd4, 1'b1, PAT_RAIL,    0,   129, 0,   -1},
        '{1'b1, SIZE_16X16, 3'd7, 3'd1, 1'b0, PAT_NOISE,   0,   -1,  60,  -1},
        '{1'b1, SIZE_4X4,   3'd1, 3'd7, 1'b1, PAT_NOISE,   0,   255, 0,   -1}
    };

    subpel_sixtap_interpolator_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_rdy),
        .i_source_pixel   (src_pix),
        .i_prior_pixel    (prior_pix),
        .i_start_of_block (sob),
        .i_horiz_phase    (hph),
        .i_vert_phase     (vph),
        .i_block_size     (bsize),
        .i_average_mode   (avg_mode),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_rdy),
        .o_out_pixel      (out_pix),
        .o_out_row        (out_row),
        .o_out_col        (out_col),
        .o_last_of_block  (out_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("subpel_sixtap_interpolator_unit test failed");
            $finish;
        end
    end

    // six-tap coefficients per eighth-pel phase, oldest pixel first
    function automatic int tap_coef(input logic [2:0] ph, input int k);
        int t [6];
        case (ph)
            3'd0: t = '{0,   0, 128,   0,   0, 0};
            3'd1: t = '{0,  -6, 123,  12,  -1, 0};
            3'd2: t = '{2, -11, 108,  36,  -8, 1};
            3'd3: t = '{0,  -9,  93,  50,  -6, 0};
            3'd4: t = '{3, -16,  77,  77, -16, 3};
            3'd5: t = '{0,  -6,  50,  93,  -9, 0};
            3'd6: t = '{1,  -8,  36, 108, -11, 2};
            default: t = '{0, -1, 12, 123, -6, 0};
        endcase
        return t[k];
    endfunction

    function automatic int blk_width(input logic [1:0] size);
        int w;
        case (size)
            SIZE_4X4:   w = 4;
            SIZE_8X4:   w = 8;
            SIZE_8X8:   w = 8;
            default:    w = 16;
        endcase
        return (w > MaxWidth) ? MaxWidth : w;
    endfunction

    function automatic int blk_height(input logic [1:0] size);
        int h;
        case (size)
            SIZE_4X4:   h = 4;
            SIZE_8X4:   h = 4;
            SIZE_8X8:   h = 8;
            default:    h = 16;
        endcase
        return h;
    endfunction

    // round, scale down by 128 and clamp to a pixel
    function automatic int descale(input int s);
        int t;
        t = s + 64;
        if (t < 0) return 0;
        t = t / 128;
        return (t > 255) ? 255 : t;
    endfunction

    function automatic logic [7:0] gen_pixel(input t_pat pat, input int level,
                                             input int r, input int c);
        logic [7:0] p;
        case (pat)
            PAT_FLAT:    p = level[7:0];
            PAT_CHECKER: p = ((r + c) % 2 != 0) ? 8'd255 : 8'd0;
            PAT_RAMP:    p = 8'((r * 16 + c * 7 + level) % 256);
            PAT_RAIL:    p = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            default:     p = 8'($urandom_range(0, 255));
        endcase
        return p;
    endfunction

    // advance the interpolator state by one accepted item; queue the pixel it completes
    task automatic predict_pel(input t_pel_in it, input int fixed_pix);
        int w, h, r, c, j, k, hsum, vsum, hv, res;
        t_pel_out o;
        if (it.start) begin
            cur_h    = it.hph;
            cur_v    = it.vph;
            cur_size = it.size;
            cur_avg  = it.avg;
            pos_row  = 0;
            pos_col  = 0;
        end
        w = blk_width(cur_size);
        h = blk_height(cur_size);
        r = pos_row;
        c = pos_col;
        if (c >= 5 && c < w + 5 && r < h + 5) begin
            j = c - 5;
            hsum = tap_coef(cur_h, 5) * int'(it.src);
            for (k = 0; k < 5; k++) hsum += tap_coef(cur_h, k) * row_taps[k];
            hv = descale(hsum);
            if (r >= 5) begin
                vsum = tap_coef(cur_v, 5) * hv;
                for (k = 0; k < 5; k++)
                    vsum += tap_coef(cur_v, k) * line_mem[((r + k) % 5) * MaxWidth + j];
                res = descale(vsum);
                if (cur_avg) res = (res + int'(it.prior) + 1) >> 1;
                if (fixed_pix >= 0) res = fixed_pix;
                o.pix  = res[7:0];
                o.row  = 4'(r - 5);
                o.col  = 4'(j);
                o.last = (r - 5 == h - 1) && (j == w - 1);
                pending_pels.push_back(o);
            end
            line_mem[(r % 5) * MaxWidth + j] = hv;
        end
        for (k = 0; k < 4; k++) row_taps[k] = row_taps[k + 1];
        row_taps[4] = int'(it.src);
        c++;
        if (c >= w + 5) begin
            c = 0;
            r++;
            if (r >= h + 5) r = 0;
        end
        pos_row = r % 32;
        pos_col = c % 32;
    endtask

    // offer one item, starting and ending at a falling edge
    task automatic push_pixel(input t_pel_in it, input int fixed_pix);
        // settings fields are don't-care off a start; keep them moving
        if (!it.start) begin
            it.hph  = 3'($urandom_range(0, 7));
            it.vph  = 3'($urandom_range(0, 7));
            it.size = 2'($urandom_range(0, 3));
            it.avg  = 1'($urandom_range(0, 1));
        end
        while (!steady && $urandom_range(0, 99) < IdlePct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid  = 1'b1;
        src_pix   = it.src;
        prior_pix = it.prior;
        sob       = it.start;
        hph       = it.hph;
        vph       = it.vph;
        bsize     = it.size;
        avg_mode  = it.avg;
        @(posedge i_clk);
        while (!in_rdy) @(posedge i_clk);
        predict_pel(it, fixed_pix);
        items_sent++;
        @(negedge i_clk);
    endtask

    // stream one window, or its first npix pixels; no start keeps the latched size
    task automatic run_window(input logic with_start, input logic [1:0] size,
                              input logic [2:0] h_ph, input logic [2:0] v_ph,
                              input logic avg, input t_pat pat, input int level,
                              input int prior_val, input int npix, input int fixed_pix);
        t_pel_in it;
        int ww, total, n;
        ww    = blk_width(with_start ? size : cur_size) + 5;
        total = ww * (blk_height(with_start ? size : cur_size) + 5);
        if (npix > 0 && npix < total) total = npix;
        for (n = 0; n < total; n++) begin
            it.src   = gen_pixel(pat, level, n / ww, n % ww);
            it.prior = (prior_val < 0) ? 8'($urandom_range(0, 255)) : prior_val[7:0];
            it.start = with_start && (n == 0);
            it.hph   = h_ph;
            it.vph   = v_ph;
            it.size  = size;
            it.avg   = avg;
            push_pixel(it, fixed_pix);
        end
    endtask

    // output side: random back-pressure
    always @(negedge i_clk) begin
        out_rdy = steady || ($urandom_range(0, 99) >= IdlePct);
    end

    task automatic flag_mismatch(input string what, input int want_v, input int got_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_pel_out want;
        if (i_rst_n && out_valid === 1'b1 && out_rdy) begin
            if (pending_pels.size() == 0) begin
                flag_mismatch("unexpected item, pixel", -1, out_pix);
            end else begin
                want = pending_pels.pop_front();
                if (out_pix !== want.pix) flag_mismatch("out_pixel", want.pix, out_pix);
                if (out_row !== want.row) flag_mismatch("out_row", want.row, out_row);
                if (out_col !== want.col) flag_mismatch("out_col", want.col, out_col);
                if (out_last !== want.last)
                    flag_mismatch("last_of_block", want.last, out_last);
            end
        end
    end

    // stimulus
    initial begin
        int blk, kind, roll;
        logic [1:0] sz;
        t_pat pat;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed windows
        for (int i = 0; i < NumDir; i++) begin
            run_window(dir_rows[i].start, dir_rows[i].size, dir_rows[i].hph, dir_rows[i].vph,
                       dir_rows[i].avg, dir_rows[i].pat, dir_rows[i].level,
                       dir_rows[i].prior, dir_rows[i].npix, dir_rows[i].want_pix);
        end

        // random windows, mostly well-formed, some cut short or run on without a start;
        // the first two run with no idling, the first of them a full 16x16 window
        blk = 0;
        while (items_sent < NumItems) begin
            blk++;
            steady = (blk <= 2);
            roll = $urandom_range(0, 99);
            if (blk == 1)       sz = SIZE_16X16;
            else if (roll < 40) sz = SIZE_4X4;
            else if (roll < 65) sz = SIZE_8X4;
            else if (roll < 92) sz = SIZE_8X8;
            else                sz = SIZE_16X16;
            roll = $urandom_range(0, 99);
            if (roll < 50)      pat = PAT_NOISE;
            else if (roll < 70) pat = PAT_RAIL;
            else if (roll < 80) pat = PAT_FLAT;
            else if (roll < 90) pat = PAT_CHECKER;
            else                pat = PAT_RAMP;
            kind = (blk == 1) ? 50 : $urandom_range(0, 99);
            if (kind < 8) begin
                run_window(1'b0, sz, 3'd0, 3'd0, 1'b0, pat, $urandom_range(0, 255), -1, 0, -1);
            end else begin
                run_window(1'b1, sz, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                           1'($urandom_range(0, 1)), pat, $urandom_range(0, 255), -1,
                           (kind < 15) ? $urandom_range(1, 120) : 0, -1);
            end
        end
        steady = 1'b0;
        in_valid = 1'b0;

        while (pending_pels.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (errors == 0) begin
            $display("subpel_sixtap_interpolator_unit test passed");
        end else begin
            $display("subpel_sixtap_interpolator_unit test failed");
        end
        $finish;
    end

endmodule
